@@ sv/bgi_pkg.sv @@
// Shared types, constants and helper functions of the bilinear grid interpolator.
// Used by every module of the block except bgi_ram; depends on nothing else.
package bgi_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = DATA_W + FRAC_W;
    localparam int AXIS_DEPTH = 64;
    localparam int IDX_W      = $clog2(AXIS_DEPTH);
    localparam int TBL_DEPTH  = AXIS_DEPTH * AXIS_DEPTH;
    localparam int POINT_W    = 7;
    localparam int MIN_POINTS = 2;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int FETCH_LAST = 4;
    localparam int MUL_LAST   = 11;

    localparam logic [1:0] MODE_HEAD  = 2'd0;
    localparam logic [1:0] MODE_POWER = 2'd1;
    localparam logic [1:0] MODE_TABLE = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    localparam logic CFG_HEAD_POINTS  = 1'b0;
    localparam logic CFG_POWER_POINTS = 1'b1;

    localparam logic SRCH_POWER = 1'b0;
    localparam logic SRCH_HEAD  = 1'b1;

    localparam logic [1:0] DIV_WB_HEAD  = 2'd0;
    localparam logic [1:0] DIV_WA_HEAD  = 2'd1;
    localparam logic [1:0] DIV_WB_POWER = 2'd2;
    localparam logic [1:0] DIV_WA_POWER = 2'd3;

    localparam logic [1:0] CMB_F1  = 2'd0;
    localparam logic [1:0] CMB_F2  = 2'd1;
    localparam logic [1:0] CMB_RES = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] load_value;
        logic signed [DATA_W-1:0] query_head;
        logic signed [DATA_W-1:0] query_power;
        logic                     batch_start;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] interpolated;
        logic                     is_query;
        logic                     degenerate;
        logic                     clamped;
    } out_item_t;

    typedef struct packed {
        logic       take;
        logic       start;
        logic       srch_cmp;
        logic       srch_sel;
        logic       fetch_en;
        logic [2:0] fetch_k;
        logic       div_start;
        logic [1:0] div_sel;
        logic       mul_en;
        logic [1:0] mul_cmb;
        logic [1:0] mul_step;
        logic       out_load;
    } bgi_cmd_t;

    typedef struct packed {
        logic is_query;
        logic srch_more;
        logic degenerate;
        logic div_done;
        logic out_free;
    } bgi_status_t;

    // Last interval index for a point count, with the count forced into range.
    function automatic logic [IDX_W-1:0] points_limit(input logic [POINT_W-1:0] n);
        logic [IDX_W-1:0] lim;
        if (n < POINT_W'(MIN_POINTS)) begin
            lim = '0;
        end else if (n > POINT_W'(AXIS_DEPTH)) begin
            lim = IDX_W'(AXIS_DEPTH - MIN_POINTS);
        end else begin
            lim = IDX_W'(n - POINT_W'(MIN_POINTS));
        end
        return lim;
    endfunction

    // Magnitude of a 33-bit difference of two 32-bit values; always fits 32 bits.
    function automatic logic [DATA_W-1:0] mag33(input logic signed [DATA_W:0] v);
        logic [DATA_W:0] t;
        t = v[DATA_W] ? -v : v;
        return t[DATA_W-1:0];
    endfunction

    // Divide a sum of products by 2^16 toward zero and saturate to 32 bits.
    function automatic logic signed [DATA_W-1:0] scale_sat(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] adj;
        logic signed [ACC_W-1:0] sh;
        logic signed [DATA_W-1:0] r;
        adj = s[ACC_W-1] ? s + ACC_W'((1 << FRAC_W) - 1) : s;
        sh  = adj >>> FRAC_W;
        if (sh > $signed({{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}})) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (sh < $signed({{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}})) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = sh[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/bilinear_grid_interpolator.sv @@
// Top level of the bilinear grid interpolator: controller plus datapath.
// Depends on bgi_pkg, bgi_ctrl, bgi_datapath.
//
//   port group   direction   handshake          payload
//   s_           in          s_valid/s_ready    s_item (in_item_t)
//   m_           out         m_valid/m_ready    m_item (out_item_t)
//   cfg_         in          cfg_we             cfg_index, cfg_wdata
//
// A load item is accepted, written to memory and then output. A query searches each axis
// (at least one compare per axis), fetches the cell corners, computes 4 weight divisions
// in the shared radix-2 divider and forms the products; a degenerate cell skips the
// divisions and the products.
// Synchronous active-low reset acts on control state, the point counts and the search cursor only.
// One item is worked on at a time; a finished result waits in the output register.
module bilinear_grid_interpolator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [bgi_pkg::POINT_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bgi_pkg::in_item_t           s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bgi_pkg::out_item_t          m_item
);
    import bgi_pkg::*;

    bgi_cmd_t    cmd;
    bgi_status_t status;

    bgi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .cmd     (cmd)
    );

    bgi_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cmd       (cmd),
        .status    (status)
    );

    assign s_ready = cmd.take;

endmodule

@@ sv/bgi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the axes and the efficiency table.
module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/bgi_div.sv @@
// Radix-2 restoring divider for the interpolation weights, one quotient bit per cycle.
// Depends on bgi_pkg.
module bgi_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bgi_pkg::NUM_W-1:0]        num_mag,
    input  logic [bgi_pkg::DATA_W-1:0]       den_mag,
    input  logic                             neg,
    output logic                             done,
    output logic signed [bgi_pkg::DATA_W-1:0] quotient
);
    import bgi_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DATA_W-1:0]    den_reg;
    logic                 neg_reg;

    logic [DATA_W:0]   shifted;
    logic              fits;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-2:0] mag;

    always_comb begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? DATA_W'(shifted - {1'b0, den_reg}) : shifted[DATA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(NUM_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num_mag;
            den_reg <= den_mag;
            neg_reg <= neg;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    // Weights saturate symmetrically at 2^31 - 1.
    assign mag      = (|quo_reg[NUM_W-1:DATA_W-1]) ? '1 : quo_reg[DATA_W-2:0];
    assign quotient = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign done     = done_reg;

endmodule

@@ sv/bgi_datapath.sv @@
// Datapath: configuration, item and output registers, axis and table memories,
// search indexes, weight divider and multiply-accumulate. Depends on bgi_pkg, bgi_ram, bgi_div.
module bgi_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bgi_pkg::POINT_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    input  bgi_pkg::in_item_t            s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bgi_pkg::out_item_t           m_item,
    input  bgi_pkg::bgi_cmd_t            cmd,
    output bgi_pkg::bgi_status_t         status
);
    import bgi_pkg::*;

    in_item_t          item_reg;
    logic [POINT_W-1:0] hp_reg, pp_reg;
    logic [IDX_W-1:0]  cursor_reg, jx_reg, jy_reg;
    logic              clamp_reg;
    logic signed [DATA_W-1:0] ha_reg, hb_reg, pa_reg, pb_reg;
    logic signed [DATA_W-1:0] z00_reg, z10_reg, z01_reg, z11_reg;
    logic signed [DATA_W-1:0] wbh_reg, wah_reg, wbp_reg, wap_reg;
    logic signed [DATA_W-1:0] f1_reg, f2_reg, res_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic              m_valid_reg;
    out_item_t         m_item_reg;

    logic [IDX_W-1:0] hlim, plim, cur_eff;
    logic             is_query, deg, take;
    logic             off_a, off_t;
    logic [IDX_W-1:0] h_raddr, p_raddr;
    logic [2*IDX_W-1:0] t_raddr;
    logic [DATA_W-1:0] h_rdata, p_rdata, t_rdata;
    logic             srch_less, srch_more;
    logic [IDX_W-1:0] srch_j, srch_lim;
    logic signed [DATA_W-1:0] srch_q, srch_d;
    logic signed [DATA_W:0] diff, den;
    logic             div_done;
    logic signed [DATA_W-1:0] div_q;
    logic signed [DATA_W-1:0] op_w, op_z;

    assign take     = s_valid && cmd.take;
    assign is_query = item_reg.mode == MODE_QUERY;
    assign hlim     = points_limit(hp_reg);
    assign plim     = points_limit(pp_reg);
    assign cur_eff  = item_reg.batch_start ? '0 : cursor_reg;
    assign deg      = (ha_reg == hb_reg) || (pa_reg == pb_reg);

    // Searches read the point above the current interval; the fetch walks the corners.
    assign off_a   = cmd.fetch_en ? cmd.fetch_k[0] : 1'b1;
    assign off_t   = cmd.fetch_en && cmd.fetch_k[1];
    assign h_raddr = jx_reg + IDX_W'(off_a);
    assign p_raddr = jy_reg + IDX_W'(off_a);
    assign t_raddr = {IDX_W'(jx_reg + IDX_W'(off_a)), IDX_W'(jy_reg + IDX_W'(off_t))};

    bgi_ram #(.WIDTH(DATA_W), .DEPTH(AXIS_DEPTH)) u_head_ram (
        .aclk  (aclk),
        .we    (cmd.start && item_reg.mode == MODE_HEAD),
        .waddr (item_reg.row),
        .wdata (item_reg.load_value),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    bgi_ram #(.WIDTH(DATA_W), .DEPTH(AXIS_DEPTH)) u_power_ram (
        .aclk  (aclk),
        .we    (cmd.start && item_reg.mode == MODE_POWER),
        .waddr (item_reg.col),
        .wdata (item_reg.load_value),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    bgi_ram #(.WIDTH(DATA_W), .DEPTH(TBL_DEPTH)) u_table_ram (
        .aclk  (aclk),
        .we    (cmd.start && item_reg.mode == MODE_TABLE),
        .waddr ({item_reg.row, item_reg.col}),
        .wdata (item_reg.load_value),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    always_comb begin
        srch_j    = (cmd.srch_sel == SRCH_HEAD) ? jx_reg : jy_reg;
        srch_lim  = (cmd.srch_sel == SRCH_HEAD) ? hlim : plim;
        srch_q    = (cmd.srch_sel == SRCH_HEAD) ? item_reg.query_head : item_reg.query_power;
        srch_d    = (cmd.srch_sel == SRCH_HEAD) ? $signed(h_rdata) : $signed(p_rdata);
        srch_less = srch_d < srch_q;
        srch_more = srch_less && (srch_j < srch_lim);
    end

    always_comb begin
        case (cmd.div_sel)
            DIV_WB_HEAD: begin
                diff = $signed({item_reg.query_head[DATA_W-1], item_reg.query_head})
                     - $signed({ha_reg[DATA_W-1], ha_reg});
                den  = $signed({hb_reg[DATA_W-1], hb_reg}) - $signed({ha_reg[DATA_W-1], ha_reg});
            end
            DIV_WA_HEAD: begin
                diff = $signed({hb_reg[DATA_W-1], hb_reg})
                     - $signed({item_reg.query_head[DATA_W-1], item_reg.query_head});
                den  = $signed({hb_reg[DATA_W-1], hb_reg}) - $signed({ha_reg[DATA_W-1], ha_reg});
            end
            DIV_WB_POWER: begin
                diff = $signed({item_reg.query_power[DATA_W-1], item_reg.query_power})
                     - $signed({pa_reg[DATA_W-1], pa_reg});
                den  = $signed({pb_reg[DATA_W-1], pb_reg}) - $signed({pa_reg[DATA_W-1], pa_reg});
            end
            default: begin
                diff = $signed({pb_reg[DATA_W-1], pb_reg})
                     - $signed({item_reg.query_power[DATA_W-1], item_reg.query_power});
                den  = $signed({pb_reg[DATA_W-1], pb_reg}) - $signed({pa_reg[DATA_W-1], pa_reg});
            end
        endcase
    end

    bgi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .num_mag  ({mag33(diff), {FRAC_W{1'b0}}}),
        .den_mag  (mag33(den)),
        .neg      (diff[DATA_W] ^ den[DATA_W]),
        .done     (div_done),
        .quotient (div_q)
    );

    // Each combine takes two products: weight a with the lower value, weight b with the upper.
    always_comb begin
        case (cmd.mul_cmb)
            CMB_F1: begin
                op_w = (cmd.mul_step == 2'd0) ? wah_reg : wbh_reg;
                op_z = (cmd.mul_step == 2'd0) ? z00_reg : z10_reg;
            end
            CMB_F2: begin
                op_w = (cmd.mul_step == 2'd0) ? wah_reg : wbh_reg;
                op_z = (cmd.mul_step == 2'd0) ? z01_reg : z11_reg;
            end
            default: begin
                op_w = (cmd.mul_step == 2'd0) ? wap_reg : wbp_reg;
                op_z = (cmd.mul_step == 2'd0) ? f1_reg : f2_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_reg      <= POINT_W'(MIN_POINTS);
            pp_reg      <= POINT_W'(MIN_POINTS);
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_HEAD_POINTS) begin
                hp_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_POWER_POINTS) begin
                pp_reg <= cfg_wdata;
            end
            if (cmd.srch_cmp && cmd.srch_sel == SRCH_POWER) begin
                cursor_reg <= srch_more ? jy_reg + 1'b1 : jy_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
        if (cmd.start) begin
            jx_reg    <= '0;
            jy_reg    <= (cur_eff > plim) ? plim : cur_eff;
            clamp_reg <= 1'b0;
        end
        if (cmd.srch_cmp) begin
            if (srch_more) begin
                if (cmd.srch_sel == SRCH_HEAD) begin
                    jx_reg <= jx_reg + 1'b1;
                end else begin
                    jy_reg <= jy_reg + 1'b1;
                end
            end else if (srch_less) begin
                clamp_reg <= 1'b1;
            end
        end
        if (cmd.fetch_en) begin
            case (cmd.fetch_k)
                3'd1: begin
                    ha_reg  <= h_rdata;
                    pa_reg  <= p_rdata;
                    z00_reg <= t_rdata;
                end
                3'd2: begin
                    hb_reg  <= h_rdata;
                    pb_reg  <= p_rdata;
                    z10_reg <= t_rdata;
                end
                3'd3: z01_reg <= t_rdata;
                3'd4: z11_reg <= t_rdata;
                default: ;
            endcase
        end
        if (div_done) begin
            case (cmd.div_sel)
                DIV_WB_HEAD:  wbh_reg <= div_q;
                DIV_WA_HEAD:  wah_reg <= div_q;
                DIV_WB_POWER: wbp_reg <= div_q;
                default:      wap_reg <= div_q;
            endcase
        end
        if (cmd.mul_en) begin
            case (cmd.mul_step)
                2'd0: prod_reg <= op_w * op_z;
                2'd1: begin
                    acc_reg  <= ACC_W'(prod_reg);
                    prod_reg <= op_w * op_z;
                end
                2'd2: acc_reg <= acc_reg + ACC_W'(prod_reg);
                default: begin
                    case (cmd.mul_cmb)
                        CMB_F1:  f1_reg  <= scale_sat(acc_reg);
                        CMB_F2:  f2_reg  <= scale_sat(acc_reg);
                        default: res_reg <= scale_sat(acc_reg);
                    endcase
                end
            endcase
        end
        if (cmd.out_load) begin
            m_item_reg.interpolated <= (is_query && !deg) ? res_reg : '0;
            m_item_reg.is_query     <= is_query;
            m_item_reg.degenerate   <= is_query && deg;
            m_item_reg.clamped      <= is_query && clamp_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign status.is_query   = is_query;
    assign status.srch_more  = srch_more;
    assign status.degenerate = deg;
    assign status.div_done   = div_done;
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

@@ sv/bgi_ctrl.sv @@
// Controller state machine that sequences loads, searches, fetches, divisions and products.
// Depends on bgi_pkg.
module bgi_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  bgi_pkg::bgi_status_t  status,
    output bgi_pkg::bgi_cmd_t     cmd
);
    import bgi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_PRD,
        ST_PCMP,
        ST_HRD,
        ST_HCMP,
        ST_FETCH,
        ST_DIV,
        ST_DIVW,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t     state_reg;
    logic [2:0] k_reg;
    logic [1:0] dsel_reg;
    logic [3:0] mcnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            dsel_reg  <= '0;
            mcnt_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_START;
                    end
                end
                ST_START: state_reg <= status.is_query ? ST_PRD : ST_OUT;
                ST_PRD:   state_reg <= ST_PCMP;
                ST_PCMP:  state_reg <= status.srch_more ? ST_PRD : ST_HRD;
                ST_HRD:   state_reg <= ST_HCMP;
                ST_HCMP: begin
                    k_reg     <= '0;
                    state_reg <= status.srch_more ? ST_HRD : ST_FETCH;
                end
                ST_FETCH: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'(FETCH_LAST)) begin
                        dsel_reg  <= DIV_WB_HEAD;
                        state_reg <= status.degenerate ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV: state_reg <= ST_DIVW;
                ST_DIVW: begin
                    if (status.div_done) begin
                        mcnt_reg <= '0;
                        if (dsel_reg == DIV_WA_POWER) begin
                            state_reg <= ST_MUL;
                        end else begin
                            dsel_reg  <= dsel_reg + 1'b1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_MUL: begin
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == 4'(MUL_LAST)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.take      = state_reg == ST_IDLE;
        cmd.start     = state_reg == ST_START;
        cmd.srch_cmp  = state_reg == ST_PCMP || state_reg == ST_HCMP;
        cmd.srch_sel  = (state_reg == ST_HCMP) ? SRCH_HEAD : SRCH_POWER;
        cmd.fetch_en  = state_reg == ST_FETCH;
        cmd.fetch_k   = k_reg;
        cmd.div_start = state_reg == ST_DIV;
        cmd.div_sel   = dsel_reg;
        cmd.mul_en    = state_reg == ST_MUL;
        cmd.mul_cmb   = mcnt_reg[3:2];
        cmd.mul_step  = mcnt_reg[1:0];
        cmd.out_load  = state_reg == ST_OUT && status.out_free;
    end

endmodule

@@ verif/tb_bilinear_grid_interpolator.sv @@
// Self-checking testbench of the bilinear grid interpolator: a generator loads the grid and
// queries it, a golden model predicts every result, and a monitor compares each transfer.
// Depends on bgi_pkg and bilinear_grid_interpolator.
module tb_bilinear_grid_interpolator;
    import bgi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam longint W_MAX      = 64'sd2147483647;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      cfg_we;
    logic      cfg_index;
    logic [POINT_W-1:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    bilinear_grid_interpolator uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always #6 aclk = ~aclk;

    // Golden copy of the grid contents and control state.
    logic signed [DATA_W-1:0] head_pts [AXIS_DEPTH];
    logic signed [DATA_W-1:0] power_pts [AXIS_DEPTH];
    logic signed [DATA_W-1:0] eff_cells [TBL_DEPTH];
    bit                       cell_written [TBL_DEPTH];
    int unsigned              cursor_gold;
    int unsigned              head_count;
    int unsigned              power_count;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        mismatches;
    int        idle_cycles;

    function automatic int unsigned in_use(int unsigned n);
        if (n < MIN_POINTS) return MIN_POINTS;
        return (n > AXIS_DEPTH) ? AXIS_DEPTH : n;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Upward walk from the start index, never past the last interval.
    function automatic int unsigned walk_axis(bit on_power, int unsigned n, int unsigned start,
                                              longint q, output bit clamp);
        int unsigned j;
        longint nxt;
        j = (start > n - 2) ? n - 2 : start;
        clamp = 1'b0;
        while (j < n - 2) begin
            nxt = on_power ? longint'(power_pts[j+1]) : longint'(head_pts[j+1]);
            if (nxt >= q) break;
            j++;
        end
        nxt = on_power ? longint'(power_pts[n-1]) : longint'(head_pts[n-1]);
        if (j == n - 2 && nxt < q) clamp = 1'b1;
        return j;
    endfunction

    function automatic longint lerp_q16(longint a, longint b, longint q, longint za,
                                        longint zb, output bit deg);
        longint d, wa, wb;
        logic signed [65:0] acc;
        logic signed [65:0] scaled;
        d = b - a;
        deg = 1'b0;
        if (d == 0) begin
            deg = 1'b1;
            return 0;
        end
        wb = sat(((q - a) * 65536) / d, -W_MAX, W_MAX);
        wa = sat(((b - q) * 65536) / d, -W_MAX, W_MAX);
        acc = 66'(wa) * 66'(za) + 66'(wb) * 66'(zb);
        scaled = acc / 66'sd65536;
        if (scaled > 66'(W_MAX)) return W_MAX;
        if (scaled < 66'(-W_MAX - 1)) return -W_MAX - 1;
        return longint'(scaled);
    endfunction

    function automatic out_item_t grid_predict(in_item_t it);
        out_item_t r;
        int unsigned nh, np, jx, jy;
        bit c1, c2, d1, d2, d3;
        longint f1, f2, qh, qp, ha, hb;
        r = '0;
        case (it.mode)
            MODE_HEAD:  head_pts[it.row] = it.load_value;
            MODE_POWER: power_pts[it.col] = it.load_value;
            MODE_TABLE: begin
                eff_cells[it.row * AXIS_DEPTH + it.col] = it.load_value;
                cell_written[it.row * AXIS_DEPTH + it.col] = 1'b1;
            end
            default: begin
                qh = it.query_head;
                qp = it.query_power;
                nh = in_use(head_count);
                np = in_use(power_count);
                if (it.batch_start) cursor_gold = 0;
                jy = walk_axis(1'b1, np, cursor_gold, qp, c1);
                cursor_gold = jy;
                jx = walk_axis(1'b0, nh, 0, qh, c2);
                ha = head_pts[jx];
                hb = head_pts[jx+1];
                f1 = lerp_q16(ha, hb, qh, eff_cells[jx*AXIS_DEPTH+jy],
                              eff_cells[(jx+1)*AXIS_DEPTH+jy], d1);
                f2 = lerp_q16(ha, hb, qh, eff_cells[jx*AXIS_DEPTH+jy+1],
                              eff_cells[(jx+1)*AXIS_DEPTH+jy+1], d2);
                f1 = lerp_q16(power_pts[jy], power_pts[jy+1], qp, f1, f2, d3);
                r.is_query = 1'b1;
                r.degenerate = d1 | d2 | d3;
                r.clamped = c1 | c2;
                r.interpolated = r.degenerate ? '0 : DATA_W'(f1);
            end
        endcase
        return r;
    endfunction

    function automatic void push_item(in_item_t it);
        pending_items.push_back(it);
        expected_results.push_back(grid_predict(it));
    endfunction

    function automatic in_item_t noise_item();
        in_item_t it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        return it;
    endfunction

    function automatic void load_point(bit on_power, int unsigned idx, logic [31:0] v);
        in_item_t it;
        it = noise_item();
        it.mode = on_power ? MODE_POWER : MODE_HEAD;
        if (on_power) it.col = IDX_W'(idx); else it.row = IDX_W'(idx);
        it.load_value = v;
        push_item(it);
    endfunction

    function automatic void load_cell(int unsigned r, int unsigned c, logic [31:0] v);
        in_item_t it;
        it = noise_item();
        it.mode = MODE_TABLE;
        it.row = IDX_W'(r);
        it.col = IDX_W'(c);
        it.load_value = v;
        push_item(it);
    endfunction

    function automatic logic [31:0] rand_cell_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($urandom_range(0, 32'h00020000)) - 32'h00010000;
        endcase
    endfunction

    // Queue a query, first loading any corner cell it would read that was never written.
    function automatic void query(logic [31:0] qh, logic [31:0] qp, bit bstart);
        in_item_t it;
        int unsigned jx, jy, cur;
        bit cl;
        cur = bstart ? 0 : cursor_gold;
        jy = walk_axis(1'b1, in_use(power_count), cur, longint'($signed(qp)), cl);
        jx = walk_axis(1'b0, in_use(head_count), 0, longint'($signed(qh)), cl);
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++)
                if (!cell_written[(jx+r)*AXIS_DEPTH + jy + c])
                    load_cell(jx + r, jy + c, rand_cell_value());
        it = noise_item();
        it.mode = MODE_QUERY;
        it.query_head = qh;
        it.query_power = qp;
        it.batch_start = bstart;
        push_item(it);
    endfunction

    function automatic logic [31:0] near_axis(bit on_power, int unsigned n);
        int unsigned k;
        logic [31:0] base;
        if ($urandom_range(0, 9) == 0) return $urandom;
        k = $urandom_range(0, n - 1);
        base = on_power ? power_pts[k] : head_pts[k];
        case ($urandom_range(0, 3))
            0: return base;
            1: return base + 32'($urandom_range(0, 32'h000fffff)) - 32'h00040000;
            default: return base + 32'($urandom_range(0, 32'h0003ffff));
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(bit idx, logic [POINT_W-1:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_POWER_POINTS) power_count = v; else head_count = v;
    endtask

    function automatic void fill_axis(bit on_power);
        logic [31:0] v;
        v = 32'($urandom_range(0, 32'h01000000)) - 32'h01800000;
        for (int k = 0; k < AXIS_DEPTH; k++) begin
            load_point(on_power, k, v);
            // An occasional repeated point makes a zero-width interval.
            if ($urandom_range(0, 11) != 0) v = v + 32'($urandom_range(1, 32'h000c0000));
        end
    endfunction

    // The count covers every queued item, including the corner loads ahead of a query.
    function automatic void random_phase(int count);
        int n;
        int queued;
        logic [31:0] qps[$];
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 2) begin
                case ($urandom_range(0, 2))
                    0: load_point(1'b0, $urandom_range(0, 63),
                                  head_pts[$urandom_range(0, 63)] + 32'($urandom_range(0, 4096)));
                    1: load_point(1'b1, $urandom_range(0, 63),
                                  power_pts[$urandom_range(0, 63)] + 32'($urandom_range(0, 4096)));
                    default: load_cell($urandom_range(0, 63), $urandom_range(0, 63),
                                       rand_cell_value());
                endcase
                n++;
            end else begin
                // A batch of queries sorted by power, the first one usually clearing the cursor.
                qps.delete();
                repeat ($urandom_range(1, 8)) qps.push_back(near_axis(1'b1, in_use(power_count)));
                qps.sort() with ($signed(item));
                foreach (qps[i]) begin
                    queued = pending_items.size();
                    query(near_axis(1'b0, in_use(head_count)), qps[i],
                          (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 19) == 0));
                    n += pending_items.size() - queued;
                end
            end
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_item <= '0;
            burst_left <= 1;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_item <= pending_items.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall rate is redrawn whenever its span runs out, sometimes to none.
    int ready_pct;
    int ready_span;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_pct <= 100;
            ready_span <= 0;
        end else begin
            if (ready_span == 0) begin
                ready_span <= $urandom_range(50, 600);
                case ($urandom_range(0, 3))
                    0: ready_pct <= 100;
                    1: ready_pct <= 70;
                    2: ready_pct <= 30;
                    default: ready_pct <= 5;
                endcase
            end else begin
                ready_span <= ready_span - 1;
            end
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Monitor and watchdog.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            idle_cycles <= 0;
            mismatches <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected transfer: %p", m_item);
                end else begin
                    want = expected_results.pop_front();
                    if (m_item !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("result mismatch: expected %p, got %p", want, m_item);
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] dup;
        cursor_gold = 0;
        head_count = 2;
        power_count = 2;
        foreach (head_pts[i]) begin
            head_pts[i] = '0;
            power_pts[i] = '0;
        end
        foreach (eff_cells[i]) begin
            eff_cells[i] = '0;
            cell_written[i] = 1'b0;
        end
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HEAD_POINTS;
        cfg_wdata = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Setup: full ascending axes.
        fill_axis(1'b0);
        fill_axis(1'b1);
        // Directed queries at the reset point counts.
        query(32'h80000000, 32'h80000000, 1'b1);
        query(32'h7fffffff, 32'h7fffffff, 1'b0);
        query(head_pts[0], power_pts[0], 1'b1);
        query(head_pts[1], power_pts[1], 1'b0);
        query(head_pts[0] - 32'h10000, power_pts[1] + 32'h10000, 1'b1);
        load_cell(0, 0, 32'h7fffffff);
        load_cell(1, 1, 32'h80000000);
        query(32'h7fffffff, 32'h80000000, 1'b1);
        dup = head_pts[1];
        load_point(1'b0, 1, head_pts[0]);
        query(head_pts[0], power_pts[0], 1'b1);
        load_point(1'b0, 1, dup);
        wait_idle();

        write_cfg(CFG_HEAD_POINTS, 7'd64);
        write_cfg(CFG_POWER_POINTS, 7'd64);
        query(32'h7fffffff, 32'h7fffffff, 1'b1);
        query(head_pts[63], power_pts[63], 1'b0);
        query(head_pts[30], power_pts[10], 1'b0);
        random_phase(90);
        wait_idle();

        // Shrunk power count without a batch start leaves a stale cursor.
        write_cfg(CFG_POWER_POINTS, 7'd5);
        write_cfg(CFG_HEAD_POINTS, 7'd0);
        query(head_pts[0], power_pts[2], 1'b0);
        random_phase(50);
        wait_idle();

        write_cfg(CFG_HEAD_POINTS, 7'd127);
        write_cfg(CFG_POWER_POINTS, 7'd1);
        random_phase(50);
        wait_idle();

        write_cfg(CFG_HEAD_POINTS, 7'd9);
        write_cfg(CFG_POWER_POINTS, 7'd100);
        random_phase(50);
        wait_idle();

        write_cfg(CFG_HEAD_POINTS, 7'd17);
        write_cfg(CFG_POWER_POINTS, 7'd3);
        random_phase(50);
        wait_idle();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/bgi_pkg.sv
sv/bgi_ram.sv
sv/bgi_div.sv
sv/bgi_datapath.sv
sv/bgi_ctrl.sv
sv/bilinear_grid_interpolator.sv
verif/tb_bilinear_grid_interpolator.sv
